>>> rtl/timestamp_kway_merge_window_top_defines.svh
// Assertion macros shared by the merge block's controller and datapath.
// Depends on nothing; the including module must have clk and arst_n.
`ifndef TIMESTAMP_KWAY_MERGE_WINDOW_TOP_DEFINES_SVH
`define TIMESTAMP_KWAY_MERGE_WINDOW_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TKMW_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tkmw: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TKMW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tkmw: next-cycle check failed");

`endif

>>> rtl/tkmw_pkg.sv
// Shared types and constants for the timestamp merge block.
// Depends on nothing; every other file but the macro header imports it.
package tkmw_pkg;

	localparam int MODE_W   = 2;
	localparam int SEL_W    = 3;
	localparam int SEC_W    = 34;
	localparam int NSEC_W   = 30;
	localparam int STAMP_W  = SEC_W + NSEC_W;
	localparam int LINE_OUT_W = 8;
	localparam int PADDR_W  = 6;
	localparam int PDATA_W  = 64;
	localparam int REG_IDX_W = 3;

	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADV   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_SINCE_EN   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SINCE_SEC  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SINCE_NSEC = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_UNTIL_EN   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_UNTIL_SEC  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_UNTIL_NSEC = 3'd5;

	typedef struct packed {
		logic              since_en;
		logic [SEC_W-1:0]  since_sec;
		logic [NSEC_W-1:0] since_nsec;
		logic              until_en;
		logic [SEC_W-1:0]  until_sec;
		logic [NSEC_W-1:0] until_nsec;
	} cfg_t;

	typedef struct packed {
		logic load;       // append the input stamp to its source
		logic clear;      // empty every source
		logic scan_clr;   // restart the head scan
		logic scan_issue; // read the head of the current scan source
		logic commit;     // write the result and consume the winner
	} cmd_t;

	typedef struct packed {
		logic scan_last;  // scan is at the final source
		logic out_busy;   // result register cannot take a new beat
	} sts_t;

endpackage

>>> rtl/tkmw_if.sv
// Valid/ready channel interfaces for the merge block's items and results.
// Depends on tkmw_pkg for field widths.
interface tkmw_in_if import tkmw_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [SEL_W-1:0]    source_sel;
	logic [SEC_W-1:0]    stamp_sec;
	logic [NSEC_W-1:0]   stamp_nsec;

	modport source (output valid, mode, source_sel, stamp_sec, stamp_nsec, input ready);
	modport sink (input valid, mode, source_sel, stamp_sec, stamp_nsec, output ready);
endinterface

interface tkmw_out_if import tkmw_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [SEL_W-1:0]      out_source;
	logic [LINE_OUT_W-1:0] out_line;
	logic [SEC_W-1:0]      out_sec;
	logic [NSEC_W-1:0]     out_nsec;
	logic                  in_window;
	logic                  done_res;

	modport source (output valid, out_source, out_line, out_sec, out_nsec, in_window,
		done_res, input ready);
	modport sink (input valid, out_source, out_line, out_sec, out_nsec, in_window,
		done_res, output ready);
endinterface

>>> rtl/timestamp_kway_merge_window_top.sv
// Top level of the timestamp k-way merge with since/until window.
// Depends on tkmw_pkg, tkmw_if, tkmw_cfg, tkmw_ctrl and tkmw_dp.
//
//   port      kind          direction  carries
//   items     valid/ready   in         mode, source_sel, stamp_sec, stamp_nsec
//   results   valid/ready   out        out_source, out_line, out_sec, out_nsec,
//                                      in_window, done_res
//   p*        APB-style     in/out     window bound registers, 8-byte stride
//
// Load and clear beats complete in the cycle in which they are accepted. An
// advance beat holds the block while the sequencer steps through accept,
// one scan step per source as the single head comparator walks the sources,
// a drain state for the registered store read and a final state that writes
// the result register. The result register parts the two sides, so a waiting
// result does not hold up loads or clears, but the next advance stalls in its
// final state until that result is taken. arst_n clears counts, cursors,
// control and registers at once; the stamp store needs no clearing pass.
module timestamp_kway_merge_window_top import tkmw_pkg::*; #(
	parameter int NUM_SOURCES      = 8,
	parameter int LINES_PER_SOURCE = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	tkmw_in_if.sink            items,
	tkmw_out_if.source         results,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	// Command and status between sequencer and datapath.
	cmd_t cmd;
	sts_t sts;
	cfg_t cfg;

	// Window bounds: the user writes them only while idle; the block does not enforce it.
	tkmw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer: accept in idle only, then step the scan.
	tkmw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_mode  (items.mode),
		.in_ready (items.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Store, scan pipeline and result register.
	tkmw_dp #(
		.NUM_SOURCES      (NUM_SOURCES),
		.LINES_PER_SOURCE (LINES_PER_SOURCE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg        (cfg),
		.in_sel     (items.source_sel),
		.in_sec     (items.stamp_sec),
		.in_nsec    (items.stamp_nsec),
		.out_ready  (results.ready),
		.out_valid  (results.valid),
		.out_source (results.out_source),
		.out_line   (results.out_line),
		.out_sec    (results.out_sec),
		.out_nsec   (results.out_nsec),
		.in_window  (results.in_window),
		.done_res   (results.done_res)
	);

endmodule

>>> rtl/tkmw_cfg.sv
// APB-style register file holding the since/until window bounds.
// Depends on tkmw_pkg.
module tkmw_cfg import tkmw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;
	cfg_t                 cfg_q;

	assign reg_idx = paddr[PADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SINCE_EN:   cfg_q.since_en   <= pwdata[0];
				REG_SINCE_SEC:  cfg_q.since_sec  <= pwdata[SEC_W-1:0];
				REG_SINCE_NSEC: cfg_q.since_nsec <= pwdata[NSEC_W-1:0];
				REG_UNTIL_EN:   cfg_q.until_en   <= pwdata[0];
				REG_UNTIL_SEC:  cfg_q.until_sec  <= pwdata[SEC_W-1:0];
				REG_UNTIL_NSEC: cfg_q.until_nsec <= pwdata[NSEC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SINCE_EN:   prdata = PDATA_W'(cfg_q.since_en);
			REG_SINCE_SEC:  prdata = PDATA_W'(cfg_q.since_sec);
			REG_SINCE_NSEC: prdata = PDATA_W'(cfg_q.since_nsec);
			REG_UNTIL_EN:   prdata = PDATA_W'(cfg_q.until_en);
			REG_UNTIL_SEC:  prdata = PDATA_W'(cfg_q.until_sec);
			REG_UNTIL_NSEC: prdata = PDATA_W'(cfg_q.until_nsec);
			default:        prdata = '0;
		endcase
	end

endmodule

>>> rtl/tkmw_ctrl.sv
// Sequencing state machine: accepts items and steps the head scan.
// Depends on tkmw_pkg and the assertion macro header.
`include "timestamp_kway_merge_window_top_defines.svh"

module tkmw_ctrl import tkmw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [MODE_W-1:0] in_mode,
	output logic              in_ready,
	input  sts_t              sts,
	output cmd_t              cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       fire;

	assign in_ready = (state_q == ST_IDLE);
	assign fire     = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load     = fire && (in_mode == MODE_LOAD);
				cmd.clear    = fire && (in_mode == MODE_CLEAR);
				cmd.scan_clr = fire && (in_mode == MODE_ADV);
				if (cmd.scan_clr) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!sts.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`TKMW_ASSERT_NEXT(a_commit_to_idle, cmd.commit, state_q == ST_IDLE && in_ready)
	`TKMW_ASSERT_NEXT(a_last_issue_drains, cmd.scan_issue && sts.scan_last, state_q == ST_DRAIN)
	`TKMW_ASSERT_NOW(a_one_cmd, 1'b1,
		$onehot0({cmd.load, cmd.clear, cmd.scan_clr, cmd.scan_issue, cmd.commit}))

endmodule

>>> rtl/tkmw_dp.sv
// Datapath: stamp store, per-source counts and cursors, head compare and
// result register. Depends on tkmw_pkg and the assertion macro header.
`include "timestamp_kway_merge_window_top_defines.svh"

module tkmw_dp import tkmw_pkg::*; #(
	parameter int NUM_SOURCES      = 8,
	parameter int LINES_PER_SOURCE = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  cfg_t                  cfg,
	input  logic [SEL_W-1:0]      in_sel,
	input  logic [SEC_W-1:0]      in_sec,
	input  logic [NSEC_W-1:0]     in_nsec,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [SEL_W-1:0]      out_source,
	output logic [LINE_OUT_W-1:0] out_line,
	output logic [SEC_W-1:0]      out_sec,
	output logic [NSEC_W-1:0]     out_nsec,
	output logic                  in_window,
	output logic                  done_res
);

	localparam int SRC_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam int LINE_W = (LINES_PER_SOURCE > 1) ? $clog2(LINES_PER_SOURCE) : 1;
	localparam int CNT_W  = $clog2(LINES_PER_SOURCE + 1);
	localparam int ADDR_W = SRC_W + LINE_W;
	localparam int MEM_DEPTH = NUM_SOURCES << LINE_W;
	localparam int WIDE_W = 7;
	localparam int CUR_WIDE_W = 17;

	logic [STAMP_W-1:0] store_q [0:MEM_DEPTH-1];

	logic [CNT_W-1:0] counts_q  [0:NUM_SOURCES-1];
	logic [CNT_W-1:0] cursors_q [0:NUM_SOURCES-1];

	logic [SRC_W-1:0]   scan_idx_q;
	logic               iss_s1;
	logic               hv_s1;
	logic [SRC_W-1:0]   src_s1;
	logic [CNT_W-1:0]   cur_s1;
	logic [STAMP_W-1:0] rd_s1;

	logic               found_q;
	logic [SRC_W-1:0]   best_src_q;
	logic [CNT_W-1:0]   best_cur_q;
	logic [STAMP_W-1:0] best_stamp_q;

	logic               out_valid_q;
	logic [SEL_W-1:0]   out_source_q;
	logic [LINE_OUT_W-1:0] out_line_q;
	logic [STAMP_W-1:0] out_stamp_q;
	logic               in_window_q;
	logic               done_q;

	logic [WIDE_W-1:0]  sel_wide;
	logic [SRC_W-1:0]   sel_idx;
	logic [SRC_W-1:0]   rd_idx;
	logic [CNT_W-1:0]   rd_count;
	logic [CNT_W-1:0]   rd_cursor;
	logic               ld_ok;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ADDR_W-1:0]  rd_addr;
	logic               take;
	logic [STAMP_W-1:0] lo_bound;
	logic [STAMP_W-1:0] hi_bound;
	logic               win_hit;
	logic [WIDE_W-1:0]  best_src_wide;
	logic [CUR_WIDE_W-1:0] best_cur_wide;

	assign sel_wide  = WIDE_W'(in_sel);
	assign sel_idx   = sel_wide[SRC_W-1:0];
	assign rd_idx    = cmd.load ? sel_idx : scan_idx_q;
	assign rd_count  = counts_q[rd_idx];
	assign rd_cursor = cursors_q[rd_idx];

	// Drop loads for absent sources or full stores.
	assign ld_ok   = (sel_wide < WIDE_W'(NUM_SOURCES)) && (rd_count < CNT_W'(LINES_PER_SOURCE));
	assign wr_addr = {sel_idx, rd_count[LINE_W-1:0]};
	assign rd_addr = {scan_idx_q, rd_cursor[LINE_W-1:0]};

	assign sts.scan_last = (scan_idx_q == SRC_W'(NUM_SOURCES - 1));
	assign sts.out_busy  = out_valid_q && !out_ready;

	// Strict less-than with ascending scan keeps ties on the lowest source.
	assign take = iss_s1 && hv_s1 && (!found_q || (rd_s1 < best_stamp_q));

	assign lo_bound = {cfg.since_sec, cfg.since_nsec};
	assign hi_bound = {cfg.until_sec, cfg.until_nsec};
	assign win_hit  = !(cfg.since_en && (best_stamp_q < lo_bound))
		&& !(cfg.until_en && (best_stamp_q > hi_bound));

	assign best_src_wide = WIDE_W'(best_src_q);
	assign best_cur_wide = CUR_WIDE_W'(best_cur_q);

	always_ff @(posedge clk) begin
		if (cmd.load && ld_ok) begin
			store_q[wr_addr] <= {in_sec, in_nsec};
		end
		rd_s1 <= store_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SOURCES; i++) begin
				counts_q[i]  <= '0;
				cursors_q[i] <= '0;
			end
		end else if (cmd.clear) begin
			for (int i = 0; i < NUM_SOURCES; i++) begin
				counts_q[i]  <= '0;
				cursors_q[i] <= '0;
			end
		end else begin
			if (cmd.load && ld_ok) begin
				counts_q[sel_idx] <= rd_count + 1'b1;
			end
			if (cmd.commit && found_q) begin
				cursors_q[best_src_q] <= best_cur_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			iss_s1     <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			iss_s1 <= cmd.scan_issue;
			if (cmd.scan_clr) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
			end else begin
				if (cmd.scan_issue && !sts.scan_last) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_issue) begin
			hv_s1  <= (rd_cursor < rd_count);
			src_s1 <= scan_idx_q;
			cur_s1 <= rd_cursor;
		end
		if (take) begin
			best_src_q   <= src_s1;
			best_cur_q   <= cur_s1;
			best_stamp_q <= rd_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (found_q) begin
				out_source_q <= best_src_wide[SEL_W-1:0];
				out_line_q   <= best_cur_wide[LINE_OUT_W-1:0];
				out_stamp_q  <= best_stamp_q;
				in_window_q  <= win_hit;
				done_q       <= 1'b0;
			end else begin
				out_source_q <= '0;
				out_line_q   <= '0;
				out_stamp_q  <= '0;
				in_window_q  <= 1'b0;
				done_q       <= 1'b1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_source = out_source_q;
	assign out_line   = out_line_q;
	assign out_sec    = out_stamp_q[STAMP_W-1:NSEC_W];
	assign out_nsec   = out_stamp_q[NSEC_W-1:0];
	assign in_window  = in_window_q;
	assign done_res   = done_q;

	`TKMW_ASSERT_NEXT(a_commit_shows_beat, cmd.commit, out_valid_q)
	`TKMW_ASSERT_NEXT(a_take_sets_found, take && !cmd.scan_clr, found_q)
	`TKMW_ASSERT_NOW(a_commit_not_busy, cmd.commit, !sts.out_busy)

endmodule

>>> tb/tb_timestamp_kway_merge_window_top.sv
// Self-checking bench for the timestamp k-way merge block with its since/until window.
// Depends on tkmw_pkg, the tkmw_in_if/tkmw_out_if channels and the RTL top level.

module tb_timestamp_kway_merge_window_top;
	import tkmw_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSRC  = 8;
	localparam int LINES = 256;

	// Mode 3 is not a real operation: the block must swallow it silently.
	localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

	localparam logic [SEC_W-1:0]  SEC_MAX  = '1;
	localparam logic [NSEC_W-1:0] NSEC_ALL = '1;
	localparam logic [NSEC_W-1:0] NSEC_TOP = NSEC_W'(999999999);

	// After the last pick, wait long enough for a whole advance to finish, with margin.
	localparam int SETTLE       = NSRC + 3 + 4;
	localparam int RANDOM_ITEMS = 600;
	localparam int CYCLE_LIMIT  = 600000;

	typedef struct packed {
		logic [SEL_W-1:0]      src;
		logic [LINE_OUT_W-1:0] line;
		logic [SEC_W-1:0]      sec;
		logic [NSEC_W-1:0]     nsec;
		logic                  in_win;
		logic                  done;
	} merge_pick_t;

	logic clk = 1'b0;
	logic arst_n;

	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	tkmw_in_if  items ();
	tkmw_out_if results ();

	timestamp_kway_merge_window_top #(
		.NUM_SOURCES      (NSRC),
		.LINES_PER_SOURCE (LINES)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items.sink),
		.results (results.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mirror of the block: stamp store, per-source counts and cursors, window registers.
	logic [STAMP_W-1:0] stamp_mem [NSRC][LINES];
	int                 line_count [NSRC];
	int                 cursor [NSRC];
	cfg_t               win;

	// Picks predicted but not yet seen on the result channel, oldest first.
	merge_pick_t picks_due[$];

	int errors      = 0;
	int items_sent  = 0;
	int n_lines     = 0;
	int n_outside   = 0;
	int n_done      = 0;
	int cycle_count = 0;

	// Idling controls, shared between the test tasks and the result-side process.
	bit src_idle_on  = 1'b1;
	bit sink_idle_on = 1'b1;
	int hold_req     = 0;

	// Predict what one accepted item does: update the mirror and queue any pick.
	function automatic void merge_predict(input logic [MODE_W-1:0] mode,
			input logic [SEL_W-1:0] sel, input logic [SEC_W-1:0] sec,
			input logic [NSEC_W-1:0] nsec);
		merge_pick_t        pick;
		bit                 found;
		int                 best;
		logic [STAMP_W-1:0] best_stamp;
		logic [STAMP_W-1:0] lo;
		logic [STAMP_W-1:0] hi;

		found      = 1'b0;
		best       = 0;
		best_stamp = '0;
		pick       = '0;
		case (mode)
			MODE_LOAD: begin
				// A full source ignores further loads.
				if (int'(sel) < NSRC && line_count[sel] < LINES) begin
					stamp_mem[sel][line_count[sel]] = {sec, nsec};
					line_count[sel]++;
				end
			end
			MODE_CLEAR: begin
				for (int i = 0; i < NSRC; i++) begin
					line_count[i] = 0;
					cursor[i]     = 0;
				end
			end
			MODE_ADV: begin
				// Walk the heads; strict less-than keeps ties on the lowest source.
				for (int i = 0; i < NSRC; i++) begin
					if (cursor[i] < line_count[i] &&
							(!found || stamp_mem[i][cursor[i]] < best_stamp)) begin
						found      = 1'b1;
						best       = i;
						best_stamp = stamp_mem[i][cursor[i]];
					end
				end
				if (!found) begin
					// Every source exhausted: report done and consume nothing.
					pick.done = 1'b1;
				end else begin
					lo          = {win.since_sec, win.since_nsec};
					hi          = {win.until_sec, win.until_nsec};
					pick.src    = SEL_W'(best);
					pick.line   = LINE_OUT_W'(cursor[best]);
					pick.sec    = best_stamp[STAMP_W-1:NSEC_W];
					pick.nsec   = best_stamp[NSEC_W-1:0];
					// Bounds are inclusive.
					pick.in_win = !((win.since_en && best_stamp < lo) ||
						(win.until_en && best_stamp > hi));
					cursor[best]++;
				end
				picks_due.push_back(pick);
			end
			default: ;
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// Offer one item, hold it until the beat is taken, then predict it.
	// Called and returns at a rising edge.
	task automatic send_item(input logic [MODE_W-1:0] mode, input logic [SEL_W-1:0] sel,
			input logic [SEC_W-1:0] sec, input logic [NSEC_W-1:0] nsec);
		int gap;
		bit took;

		gap  = 0;
		took = 1'b0;
		if (src_idle_on && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 8);
		if (gap > 0) begin
			items.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items.valid      <= 1'b1;
		items.mode       <= mode;
		items.source_sel <= sel;
		items.stamp_sec  <= sec;
		items.stamp_nsec <= nsec;
		// Sample ready mid-cycle, away from the edge at which it may change.
		while (!took) begin
			@(negedge clk);
			took = items.ready;
			@(posedge clk);
		end
		merge_predict(mode, sel, sec, nsec);
		if (mode != MODE_NOP)
			items_sent++;
	endtask

	// Random payload fields for items whose stamp and source do not matter.
	task automatic send_bare(input logic [MODE_W-1:0] mode);
		send_item(mode, SEL_W'($urandom), SEC_W'({$urandom, $urandom}), NSEC_W'($urandom));
	endtask

	// Drop valid and hold off until every predicted pick has come back and the block is idle.
	task automatic wait_drain();
		items.valid <= 1'b0;
		while (picks_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// One APB write. psel stays high so back-to-back writes need no extra step.
	task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
		case (idx)
			REG_SINCE_EN:   win.since_en   = value[0];
			REG_SINCE_SEC:  win.since_sec  = value[SEC_W-1:0];
			REG_SINCE_NSEC: win.since_nsec = value[NSEC_W-1:0];
			REG_UNTIL_EN:   win.until_en   = value[0];
			REG_UNTIL_SEC:  win.until_sec  = value[SEC_W-1:0];
			REG_UNTIL_NSEC: win.until_nsec = value[NSEC_W-1:0];
			default: ;
		endcase
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Program the whole window; only call while the block is idle.
	task automatic write_window(input logic lo_en, input logic [SEC_W-1:0] lo_sec,
			input logic [NSEC_W-1:0] lo_nsec, input logic hi_en,
			input logic [SEC_W-1:0] hi_sec, input logic [NSEC_W-1:0] hi_nsec);
		set_reg(REG_SINCE_EN, PDATA_W'(lo_en));
		set_reg(REG_SINCE_SEC, PDATA_W'(lo_sec));
		set_reg(REG_SINCE_NSEC, PDATA_W'(lo_nsec));
		set_reg(REG_UNTIL_EN, PDATA_W'(hi_en));
		set_reg(REG_UNTIL_SEC, PDATA_W'(hi_sec));
		set_reg(REG_UNTIL_NSEC, PDATA_W'(hi_nsec));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Ordering at reset settings: done on empty, extremes, ties, nsec above a second.
	task automatic test_directed_order();
		send_bare(MODE_ADV);
		send_item(MODE_LOAD, 3'd0, '0, '0);
		send_item(MODE_LOAD, 3'd7, SEC_MAX, NSEC_ALL);
		send_item(MODE_LOAD, 3'd3, SEC_W'(5), NSEC_TOP);
		send_item(MODE_LOAD, 3'd1, SEC_W'(5), NSEC_TOP);
		send_item(MODE_LOAD, 3'd2, SEC_W'(5), NSEC_W'(1000000000));
		send_item(MODE_LOAD, 3'd1, SEC_W'(5), NSEC_TOP);
		send_item(MODE_NOP, 3'd5, SEC_MAX, NSEC_ALL);
		repeat (7) send_bare(MODE_ADV);
	endtask

	// Clear with lines pending, then reuse the sources.
	task automatic test_clear_and_noop();
		send_item(MODE_LOAD, 3'd4, SEC_W'(100), NSEC_W'(7));
		send_item(MODE_LOAD, 3'd6, SEC_W'(100), NSEC_W'(6));
		send_bare(MODE_ADV);
		send_bare(MODE_CLEAR);
		send_bare(MODE_ADV);
		send_bare(MODE_NOP);
		send_item(MODE_LOAD, 3'd4, SEC_W'(1), NSEC_W'(1));
		send_bare(MODE_ADV);
		send_bare(MODE_ADV);
	endtask

	// Stamps on, just inside and just outside each bound, with the until bound alone too.
	task automatic test_window_bounds();
		wait_drain();
		write_window(1'b1, SEC_W'(10), NSEC_W'(500), 1'b1, SEC_W'(12), NSEC_W'(0));
		send_bare(MODE_CLEAR);
		send_item(MODE_LOAD, 3'd0, SEC_W'(10), NSEC_W'(499));
		send_item(MODE_LOAD, 3'd1, SEC_W'(10), NSEC_W'(500));
		send_item(MODE_LOAD, 3'd2, SEC_W'(11), NSEC_W'(0));
		send_item(MODE_LOAD, 3'd3, SEC_W'(12), NSEC_W'(0));
		send_item(MODE_LOAD, 3'd4, SEC_W'(12), NSEC_W'(1));
		send_item(MODE_LOAD, 3'd5, SEC_W'(9), NSEC_TOP);
		repeat (7) send_bare(MODE_ADV);
		wait_drain();
		write_window(1'b0, SEC_W'(10), NSEC_W'(500), 1'b1, SEC_W'(3), NSEC_W'(0));
		send_item(MODE_LOAD, 3'd6, SEC_W'(2), NSEC_TOP);
		send_item(MODE_LOAD, 3'd6, SEC_W'(3), NSEC_W'(1));
		repeat (3) send_bare(MODE_ADV);
		wait_drain();
		// Inverted extremes: nothing can lie inside.
		write_window(1'b1, SEC_MAX, NSEC_TOP, 1'b1, '0, '0);
		send_item(MODE_LOAD, 3'd2, SEC_MAX, NSEC_TOP);
		send_item(MODE_LOAD, 3'd3, '0, '0);
		repeat (3) send_bare(MODE_ADV);
	endtask

	// Overfill one source: loads past its capacity must be dropped.
	task automatic test_full_source();
		wait_drain();
		write_window(1'b1, '0, '0, 1'b1, SEC_MAX, NSEC_TOP);
		send_bare(MODE_CLEAR);
		for (int i = 0; i < LINES + 2; i++)
			send_item(MODE_LOAD, 3'd5, SEC_W'(i), NSEC_W'($urandom_range(0, 999999999)));
		send_item(MODE_LOAD, 3'd2, '0, '0);
		repeat (LINES + 4) send_bare(MODE_ADV);
	endtask

	// Hold the result side off for a long stretch so the input stalls, then drain.
	task automatic test_backpressure();
		wait_drain();
		send_bare(MODE_CLEAR);
		repeat (20) send_item(MODE_LOAD, SEL_W'($urandom), SEC_W'($urandom_range(0, 3)),
			NSEC_W'($urandom_range(0, 3)));
		hold_req = 400;
		repeat (22) send_bare(MODE_ADV);
		wait_drain();
	endtask

	task automatic pick_random_window();
		logic [SEC_W-1:0]   lo_sec;
		logic [NSEC_W-1:0]  lo_ns;
		logic [STAMP_W-1:0] hi;

		lo_sec = SEC_W'({$urandom, $urandom});
		lo_ns  = NSEC_W'($urandom_range(0, 999999000));
		hi     = {lo_sec, lo_ns} + STAMP_W'($urandom_range(0, 12));
		case ($urandom_range(0, 4))
			0: write_window(1'b1, '0, '0, 1'b1, SEC_MAX, NSEC_TOP);
			1: write_window(1'b1, SEC_MAX, NSEC_TOP, 1'b1, '0, '0);
			4: write_window(1'b0, lo_sec, NSEC_W'($urandom_range(0, 999999999)), 1'b0,
				SEC_W'({$urandom, $urandom}), NSEC_W'($urandom_range(0, 999999999)));
			default: write_window(1'($urandom), lo_sec, lo_ns, 1'($urandom),
				hi[STAMP_W-1:NSEC_W], hi[NSEC_W-1:0]);
		endcase
	endtask

	// Episodes of mostly time-ordered loads per source followed by advances,
	// with out-of-order stamps, unused modes and short or long advance runs mixed in.
	task automatic test_random_merge();
		logic [STAMP_W-1:0] head [NSRC];
		logic [STAMP_W-1:0] base;
		logic [STAMP_W-1:0] p;
		logic [SEL_W-1:0]   s;
		int                 n_load;
		int                 n_adv;
		int                 episode;
		int                 start;

		episode = 0;
		start   = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			if (episode % 5 == 0) begin
				wait_drain();
				pick_random_window();
			end
			// Run the last stretch flat out on both sides.
			if (items_sent - start > RANDOM_ITEMS * 4 / 5) begin
				src_idle_on  = 1'b0;
				sink_idle_on = 1'b0;
			end
			// Start the sources near the lower bound half the time so the window matters.
			if ($urandom_range(0, 1))
				base = {win.since_sec, win.since_nsec} - STAMP_W'($urandom_range(0, 8));
			else
				base = {$urandom, $urandom};
			for (int i = 0; i < NSRC; i++)
				head[i] = base + STAMP_W'($urandom_range(0, 3));
			if ($urandom_range(0, 3) != 0)
				send_bare(MODE_CLEAR);
			n_load = $urandom_range(1, 24);
			repeat (n_load) begin
				s = ($urandom_range(0, 2) == 0) ? SEL_W'($urandom_range(0, 1)) : SEL_W'($urandom);
				case ($urandom_range(0, 15))
					0: p = {$urandom, $urandom};
					1: begin
						head[s] = head[s] + STAMP_W'($urandom);
						p       = head[s];
					end
					default: begin
						head[s] = head[s] + STAMP_W'($urandom_range(0, 4));
						p       = head[s];
					end
				endcase
				send_item(MODE_LOAD, s, p[STAMP_W-1:NSEC_W], p[NSEC_W-1:0]);
				if ($urandom_range(0, 19) == 0)
					send_bare(MODE_NOP);
			end
			if ($urandom_range(0, 4) == 0)
				n_adv = $urandom_range(0, n_load);
			else
				n_adv = n_load + $urandom_range(0, 2);
			repeat (n_adv) send_bare(MODE_ADV);
			episode++;
		end
	endtask

	initial begin : run
		arst_n           <= 1'b0;
		items.valid      <= 1'b0;
		items.mode       <= MODE_LOAD;
		items.source_sel <= '0;
		items.stamp_sec  <= '0;
		items.stamp_nsec <= '0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= '0;
		win = '0;
		for (int i = 0; i < NSRC; i++) begin
			line_count[i] = 0;
			cursor[i]     = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_order();
		test_clear_and_noop();
		test_window_bounds();
		test_full_source();
		test_backpressure();
		test_random_merge();

		wait_drain();
		$display("merged %0d lines (%0d outside the window) and %0d done beats from %0d items,",
			n_lines, n_outside, n_done, items_sent);
		$display("across ties, overfilled sources, clears and inclusive and inverted windows");
		if (errors == 0)
			$display("PASS timestamp_kway_merge_window_top");
		else
			$display("FAIL timestamp_kway_merge_window_top");
		$finish;
	end

	// Result side: random stall bursts, plus a long hold-off counted here on request.
	initial begin : result_sink
		int stall_left;
		int hold_left;

		stall_left = 0;
		hold_left  = 0;
		results.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				results.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				results.ready <= 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(1, 8) - 1;
				results.ready <= 1'b0;
			end else begin
				results.ready <= 1'b1;
			end
		end
	end

	// Compare each result beat with the oldest pick, mid-cycle before the accepting edge.
	always @(negedge clk) begin : result_check
		merge_pick_t want;

		if (arst_n && results.valid && results.ready) begin
			if (picks_due.size() == 0) begin
				$error("result beat with nothing expected: source %0d line %0d done %0d",
					results.out_source, results.out_line, results.done_res);
				errors++;
			end else begin
				want = picks_due.pop_front();
				check_field("out_source", want.src, results.out_source);
				check_field("out_line", want.line, results.out_line);
				check_field("out_sec", want.sec, results.out_sec);
				check_field("out_nsec", want.nsec, results.out_nsec);
				check_field("in_window", want.in_win, results.in_window);
				check_field("done_res", want.done, results.done_res);
				if (want.done)
					n_done++;
				else begin
					n_lines++;
					if (!want.in_win)
						n_outside++;
				end
			end
		end
	end

	// Watchdog: end the run if it stalls.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles with %0d picks outstanding", cycle_count,
			picks_due.size());
		$display("FAIL timestamp_kway_merge_window_top");
		$finish;
	end

endmodule
